// File: src/sed_pkg.sv
// Package for the string escape decoder: byte constants, escape modes, error codes,
// the result record and the hex digit decoder. No dependencies.
`default_nettype none

package sed_pkg;

    localparam int BYTE_W  = 8;
    localparam int ERR_W   = 3;
    localparam int ACC_W   = 16;
    localparam int DIG_W   = 3;
    localparam int SURR_W  = 10;
    localparam int CP_W    = 21;
    localparam int RES_MAX = 5;
    localparam int RES_IDX_W = $clog2(RES_MAX);
    localparam int RES_CNT_W = $clog2(RES_MAX + 1);

    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_V      = 8'h76;
    localparam logic [BYTE_W-1:0] CH_X_LO   = 8'h78;
    localparam logic [BYTE_W-1:0] CH_X_UP   = 8'h58;
    localparam logic [BYTE_W-1:0] CH_U_LO   = 8'h75;
    localparam logic [BYTE_W-1:0] CH_U_UP   = 8'h55;

    localparam logic [BYTE_W-1:0] BS_CODE = 8'h08;
    localparam logic [BYTE_W-1:0] FF_CODE = 8'h0C;
    localparam logic [BYTE_W-1:0] LF_CODE = 8'h0A;
    localparam logic [BYTE_W-1:0] CR_CODE = 8'h0D;
    localparam logic [BYTE_W-1:0] HT_CODE = 8'h09;
    localparam logic [BYTE_W-1:0] VT_CODE = 8'h0B;

    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    localparam logic [DIG_W-1:0] HEX2_DIGITS = 3'd2;
    localparam logic [DIG_W-1:0] HEX4_DIGITS = 3'd4;

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_ESCAPE = 4'b0010,
        MODE_HEX2   = 4'b0100,
        MODE_HEX4   = 4'b1000
    } mode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE        = 3'd0,
        ERR_UNKNOWN_ESC = 3'd1,
        ERR_BAD_HEX     = 3'd2,
        ERR_UNPAIRED_HI = 3'd3,
        ERR_REPEATED_HI = 3'd4,
        ERR_UNPAIRED_LO = 3'd5
    } err_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              run_last;
        logic              string_done;
        logic [ERR_W-1:0]  error_code;
    } res_t;

    // Returns a valid flag in the top bit and the digit value below it.
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/sed_in_if.sv
// Input channel of the string escape decoder: one raw literal byte per transfer.
// Depends on sed_pkg.
`default_nettype none

interface sed_in_if import sed_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// File: src/sed_out_if.sv
// Output channel of the string escape decoder: one decoded byte or status per transfer.
// Depends on sed_pkg.
`default_nettype none

interface sed_out_if import sed_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              string_done;
    logic [ERR_W-1:0]  error_code;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output string_done, output error_code, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input run_last,
                  input string_done, input error_code, output ready);
endinterface

`default_nettype wire

// File: src/string_escape_decoder_core.sv
// String escape decoder top level. Depends on sed_pkg, sed_in_if and sed_out_if.
// An input byte is registered, decoded into the result buffer and offered from there.
// Throughput: one input byte per cycle while each byte gives at most one result and the
// output takes it; a byte with k results holds the result buffer until all are taken.
// Reset: asynchronous and active low; clears the escape state and both pipeline stages.
`default_nettype none

module string_escape_decoder_core import sed_pkg::*; (
    input  wire       clk,
    input  wire       rst_n,
    sed_in_if.sink    in_ch,
    sed_out_if.source out_ch
);

    logic                 in_full_reg, in_full_next;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_last_reg;

    mode_t                mode_reg, mode_next;
    logic [DIG_W-1:0]     dig_reg, dig_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 hp_reg, hp_next;
    logic [SURR_W-1:0]    hb_reg, hb_next;
    err_t                 err_reg, err_next;

    res_t                 buf_reg [RES_MAX];
    res_t                 batch [RES_MAX];
    logic [RES_IDX_W-1:0] rd_reg, rd_next;
    logic [RES_CNT_W-1:0] left_reg, left_next;
    logic [RES_CNT_W-1:0] batch_cnt;

    logic                 take, pop, buf_free, process;

    logic                 raw_emit, cp_emit;
    logic [BYTE_W-1:0]    raw_b;
    logic [CP_W-1:0]      cp;
    logic [4:0]           hx;
    logic [ACC_W-1:0]     acc_shift;
    logic [DIG_W-1:0]     dig_dec;
    logic [2:0]           n_bytes;
    logic [BYTE_W-1:0]    ob [4];
    err_t                 st_err;

    assign pop      = out_ch.valid && out_ch.ready;
    assign buf_free = (left_reg == '0) || (left_reg == RES_CNT_W'(1) && pop);
    assign process  = in_full_reg && buf_free;
    assign in_ch.ready = !in_full_reg || process;
    assign take     = in_ch.valid && in_ch.ready;

    // Escape decoding for the registered byte.
    always_comb
    begin
        mode_next = mode_reg;
        dig_next  = dig_reg;
        acc_next  = acc_reg;
        hp_next   = hp_reg;
        hb_next   = hb_reg;
        err_next  = err_reg;
        raw_emit  = 1'b0;
        raw_b     = in_byte_reg;
        cp_emit   = 1'b0;
        cp        = '0;
        hx        = hex_value(in_byte_reg);
        acc_shift = {acc_reg[ACC_W-5:0], hx[3:0]};
        dig_dec   = dig_reg - DIG_W'(1);

        if (err_reg == ERR_NONE)
        begin
            unique case (mode_reg)
                MODE_NORMAL:
                begin
                    if (in_byte_reg == CH_DQUOTE)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else if (in_byte_reg == CH_BSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else if (hp_reg)
                    begin
                        err_next = ERR_UNPAIRED_HI;
                    end
                    else
                    begin
                        raw_emit = 1'b1;
                    end
                end
                MODE_ESCAPE:
                begin
                    mode_next = MODE_NORMAL;
                    if (hp_reg && in_byte_reg != CH_U_LO)
                    begin
                        err_next = ERR_UNPAIRED_HI;
                    end
                    else
                    begin
                        unique case (in_byte_reg)
                            CH_SQUOTE: begin raw_emit = 1'b1; raw_b = CH_SQUOTE; end
                            CH_DQUOTE: begin raw_emit = 1'b1; raw_b = CH_DQUOTE; end
                            CH_BSLASH: begin raw_emit = 1'b1; raw_b = CH_BSLASH; end
                            CH_B:      begin raw_emit = 1'b1; raw_b = BS_CODE; end
                            CH_F:      begin raw_emit = 1'b1; raw_b = FF_CODE; end
                            CH_N:      begin raw_emit = 1'b1; raw_b = LF_CODE; end
                            CH_R:      begin raw_emit = 1'b1; raw_b = CR_CODE; end
                            CH_T:      begin raw_emit = 1'b1; raw_b = HT_CODE; end
                            CH_V:      begin raw_emit = 1'b1; raw_b = VT_CODE; end
                            CH_X_LO, CH_X_UP:
                            begin
                                mode_next = MODE_HEX2;
                                dig_next  = HEX2_DIGITS;
                                acc_next  = '0;
                            end
                            CH_U_LO, CH_U_UP:
                            begin
                                mode_next = MODE_HEX4;
                                dig_next  = HEX4_DIGITS;
                                acc_next  = '0;
                            end
                            default:
                            begin
                                err_next = ERR_UNKNOWN_ESC;
                            end
                        endcase
                    end
                end
                MODE_HEX2, MODE_HEX4:
                begin
                    if (!hx[4])
                    begin
                        err_next = ERR_BAD_HEX;
                    end
                    else
                    begin
                        acc_next = acc_shift;
                        dig_next = dig_dec;
                        if (dig_dec == '0)
                        begin
                            mode_next = MODE_NORMAL;
                            if (mode_reg == MODE_HEX2)
                            begin
                                raw_emit = 1'b1;
                                raw_b    = acc_shift[BYTE_W-1:0];
                            end
                            else if (acc_shift[ACC_W-1:SURR_W] == SURR_HIGH_TAG)
                            begin
                                if (hp_reg)
                                begin
                                    err_next = ERR_REPEATED_HI;
                                end
                                else
                                begin
                                    hp_next = 1'b1;
                                    hb_next = acc_shift[SURR_W-1:0];
                                end
                            end
                            else if (acc_shift[ACC_W-1:SURR_W] == SURR_LOW_TAG)
                            begin
                                if (!hp_reg)
                                begin
                                    err_next = ERR_UNPAIRED_LO;
                                end
                                else
                                begin
                                    cp_emit = 1'b1;
                                    cp      = SUPP_BASE + CP_W'({hb_reg, acc_shift[SURR_W-1:0]});
                                    hp_next = 1'b0;
                                    hb_next = '0;
                                end
                            end
                            else if (hp_reg)
                            begin
                                err_next = ERR_UNPAIRED_HI;
                            end
                            else
                            begin
                                cp_emit = 1'b1;
                                cp      = CP_W'(acc_shift);
                            end
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                end
            endcase
        end

        if (err_next != ERR_NONE)
        begin
            st_err = err_next;
        end
        else if (mode_next == MODE_ESCAPE)
        begin
            st_err = ERR_UNKNOWN_ESC;
        end
        else if (mode_next != MODE_NORMAL)
        begin
            st_err = ERR_BAD_HEX;
        end
        else if (hp_next)
        begin
            st_err = ERR_UNPAIRED_HI;
        end
        else
        begin
            st_err = ERR_NONE;
        end

        if (in_last_reg)
        begin
            mode_next = MODE_NORMAL;
            dig_next  = '0;
            acc_next  = '0;
            hp_next   = 1'b0;
            hb_next   = '0;
            err_next  = ERR_NONE;
        end
    end

    // UTF-8 encoding and assembly of the result batch.
    always_comb
    begin
        ob[0] = raw_b;
        ob[1] = '0;
        ob[2] = '0;
        ob[3] = '0;
        n_bytes = 3'd0;
        if (raw_emit)
        begin
            n_bytes = 3'd1;
        end
        else if (cp_emit)
        begin
            if (cp < 21'h80)
            begin
                n_bytes = 3'd1;
                ob[0]   = cp[7:0];
            end
            else if (cp < 21'h800)
            begin
                n_bytes = 3'd2;
                ob[0]   = {3'b110, cp[10:6]};
                ob[1]   = {2'b10, cp[5:0]};
            end
            else if (cp < 21'h10000)
            begin
                n_bytes = 3'd3;
                ob[0]   = {4'b1110, cp[15:12]};
                ob[1]   = {2'b10, cp[11:6]};
                ob[2]   = {2'b10, cp[5:0]};
            end
            else
            begin
                n_bytes = 3'd4;
                ob[0]   = {5'b11110, cp[20:18]};
                ob[1]   = {2'b10, cp[17:12]};
                ob[2]   = {2'b10, cp[11:6]};
                ob[3]   = {2'b10, cp[5:0]};
            end
        end

        batch_cnt = RES_CNT_W'(n_bytes) + RES_CNT_W'(in_last_reg);

        for (int i = 0; i < RES_MAX; i++)
        begin
            batch[i] = '0;
            if (RES_CNT_W'(i) < RES_CNT_W'(n_bytes))
            begin
                batch[i].out_byte   = ob[i % 4];
                batch[i].byte_valid = 1'b1;
            end
            else if (RES_CNT_W'(i) == RES_CNT_W'(n_bytes) && in_last_reg)
            begin
                batch[i].string_done = 1'b1;
                batch[i].error_code  = st_err;
            end
            batch[i].run_last = (batch_cnt != '0) &&
                                (RES_CNT_W'(i) == batch_cnt - RES_CNT_W'(1));
        end
    end

    always_comb
    begin
        in_full_next = in_full_reg;
        if (take)
        begin
            in_full_next = 1'b1;
        end
        else if (process)
        begin
            in_full_next = 1'b0;
        end

        left_next = left_reg;
        rd_next   = rd_reg;
        if (process)
        begin
            left_next = batch_cnt;
            rd_next   = '0;
        end
        else if (pop)
        begin
            left_next = left_reg - RES_CNT_W'(1);
            rd_next   = rd_reg + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
            left_reg    <= '0;
            rd_reg      <= '0;
            mode_reg    <= MODE_NORMAL;
            dig_reg     <= '0;
            acc_reg     <= '0;
            hp_reg      <= 1'b0;
            hb_reg      <= '0;
            err_reg     <= ERR_NONE;
        end
        else
        begin
            in_full_reg <= in_full_next;
            left_reg    <= left_next;
            rd_reg      <= rd_next;
            if (process)
            begin
                mode_reg <= mode_next;
                dig_reg  <= dig_next;
                acc_reg  <= acc_next;
                hp_reg   <= hp_next;
                hb_reg   <= hb_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= in_ch.in_byte;
            in_last_reg <= in_ch.in_last;
        end
        if (process)
        begin
            for (int i = 0; i < RES_MAX; i++)
            begin
                buf_reg[i] <= batch[i];
            end
        end
    end

    assign out_ch.valid       = (left_reg != '0);
    assign out_ch.out_byte    = buf_reg[rd_reg].out_byte;
    assign out_ch.byte_valid  = buf_reg[rd_reg].byte_valid;
    assign out_ch.run_last    = buf_reg[rd_reg].run_last;
    assign out_ch.string_done = buf_reg[rd_reg].string_done;
    assign out_ch.error_code  = buf_reg[rd_reg].error_code;

`ifndef ASSERT_OFF
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rd_reg) + 32'(left_reg) <= RES_MAX)
        else $error("result buffer index overran its depth");

    a_batch_shown: assert property (@(posedge clk) disable iff (!rst_n)
        process && batch_cnt != '0 |=> out_ch.valid)
        else $error("decoded batch not offered on the output");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.string_done |-> out_ch.run_last && !out_ch.byte_valid)
        else $error("status result is not the last of its byte");

    a_byte_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.byte_valid |-> out_ch.error_code == ERR_NONE)
        else $error("decoded byte carries an error code");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        process && in_last_reg |=> mode_reg == MODE_NORMAL && !hp_reg && err_reg == ERR_NONE)
        else $error("escape state not cleared after the final byte");
`endif

endmodule

`default_nettype wire

// File: verif/string_escape_decoder_core_test.sv
// Self-checking testbench for string_escape_decoder_core: literals with escapes, hex and
// surrogate pairs are driven byte by byte, and each output transfer is checked in order against a
// decoded-byte predictor. Depends on sed_pkg, sed_in_if and sed_out_if.
`default_nettype none

module string_escape_decoder_core_test import sed_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TARGET_BYTES = 430;
    localparam int QUIET_TAIL = 60;
    localparam int HOLD_AFTER = 150;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } lit_byte_t;

    class literal_decoder_model;
        mode_t             mode;
        logic [DIG_W-1:0]  digits_left;
        logic [ACC_W-1:0]  acc;
        bit                high_pending;
        logic [SURR_W-1:0] high_bits;
        err_t              err;
        res_t              step_q[$];
        res_t              decoded_q[$];
        int                failures;
        int                reported;

        function new();
            clear();
            failures = 0;
            reported = 0;
        endfunction

        function void clear();
            mode = MODE_NORMAL;
            digits_left = '0;
            acc = '0;
            high_pending = 1'b0;
            high_bits = '0;
            err = ERR_NONE;
        endfunction

        function int nibble_of(logic [BYTE_W-1:0] c);
            if (c >= "0" && c <= "9")
            begin
                return c - "0";
            end
            if (c >= "a" && c <= "f")
            begin
                return c - "a" + 10;
            end
            if (c >= "A" && c <= "F")
            begin
                return c - "A" + 10;
            end
            return -1;
        endfunction

        function void emit(logic [BYTE_W-1:0] b);
            res_t r;
            r.out_byte = b;
            r.byte_valid = 1'b1;
            r.run_last = 1'b0;
            r.string_done = 1'b0;
            r.error_code = ERR_NONE;
            step_q.push_back(r);
        endfunction

        function void emit_utf8(logic [CP_W-1:0] cp);
            if (cp < 21'h80)
            begin
                emit(cp[7:0]);
            end
            else if (cp < 21'h800)
            begin
                emit({3'b110, cp[10:6]});
                emit({2'b10, cp[5:0]});
            end
            else if (cp < 21'h10000)
            begin
                emit({4'b1110, cp[15:12]});
                emit({2'b10, cp[11:6]});
                emit({2'b10, cp[5:0]});
            end
            else
            begin
                emit({5'b11110, cp[20:18]});
                emit({2'b10, cp[17:12]});
                emit({2'b10, cp[11:6]});
                emit({2'b10, cp[5:0]});
            end
        endfunction

        function void finish_code_unit(logic [ACC_W-1:0] v);
            if (v >= 16'hD800 && v <= 16'hDBFF)
            begin
                if (high_pending)
                begin
                    err = ERR_REPEATED_HI;
                end
                else
                begin
                    high_pending = 1'b1;
                    high_bits = v[9:0];
                end
            end
            else if (v >= 16'hDC00 && v <= 16'hDFFF)
            begin
                if (!high_pending)
                begin
                    err = ERR_UNPAIRED_LO;
                end
                else
                begin
                    emit_utf8(21'h10000 + {high_bits, v[9:0]});
                    high_pending = 1'b0;
                    high_bits = '0;
                end
            end
            else if (high_pending)
            begin
                err = ERR_UNPAIRED_HI;
            end
            else
            begin
                emit_utf8({5'd0, v});
            end
        endfunction

        function void take_escape(logic [BYTE_W-1:0] c);
            mode = MODE_NORMAL;
            if (high_pending && c != CH_U_LO)
            begin
                err = ERR_UNPAIRED_HI;
                return;
            end
            case (c)
                CH_SQUOTE: emit(CH_SQUOTE);
                CH_DQUOTE: emit(CH_DQUOTE);
                CH_BSLASH: emit(CH_BSLASH);
                CH_B: emit(BS_CODE);
                CH_F: emit(FF_CODE);
                CH_N: emit(LF_CODE);
                CH_R: emit(CR_CODE);
                CH_T: emit(HT_CODE);
                CH_V: emit(VT_CODE);
                CH_X_LO, CH_X_UP:
                begin
                    mode = MODE_HEX2;
                    digits_left = HEX2_DIGITS;
                    acc = '0;
                end
                CH_U_LO, CH_U_UP:
                begin
                    mode = MODE_HEX4;
                    digits_left = HEX4_DIGITS;
                    acc = '0;
                end
                default: err = ERR_UNKNOWN_ESC;
            endcase
        endfunction

        // Works out every result that one accepted input transfer causes.
        function void take_input_byte(logic [BYTE_W-1:0] c, logic last);
            res_t status;
            res_t tail;
            err_t final_err;
            int n;
            step_q.delete();
            if (err == ERR_NONE)
            begin
                if (mode == MODE_NORMAL)
                begin
                    if (c == CH_BSLASH)
                    begin
                        mode = MODE_ESCAPE;
                    end
                    else if (c != CH_DQUOTE)
                    begin
                        if (high_pending)
                        begin
                            err = ERR_UNPAIRED_HI;
                        end
                        else
                        begin
                            emit(c);
                        end
                    end
                end
                else if (mode == MODE_ESCAPE)
                begin
                    take_escape(c);
                end
                else
                begin
                    n = nibble_of(c);
                    if (n < 0)
                    begin
                        err = ERR_BAD_HEX;
                    end
                    else
                    begin
                        acc = {acc[11:0], 4'(n)};
                        digits_left = digits_left - 1'b1;
                        if (digits_left == 0)
                        begin
                            if (mode == MODE_HEX2)
                            begin
                                mode = MODE_NORMAL;
                                emit(acc[7:0]);
                            end
                            else
                            begin
                                mode = MODE_NORMAL;
                                finish_code_unit(acc);
                            end
                        end
                    end
                end
            end
            if (last)
            begin
                final_err = err;
                if (final_err == ERR_NONE)
                begin
                    if (mode == MODE_ESCAPE)
                    begin
                        final_err = ERR_UNKNOWN_ESC;
                    end
                    else if (mode != MODE_NORMAL)
                    begin
                        final_err = ERR_BAD_HEX;
                    end
                    else if (high_pending)
                    begin
                        final_err = ERR_UNPAIRED_HI;
                    end
                end
                status.out_byte = '0;
                status.byte_valid = 1'b0;
                status.run_last = 1'b0;
                status.string_done = 1'b1;
                status.error_code = final_err;
                step_q.push_back(status);
                clear();
            end
            if (step_q.size() > 0)
            begin
                tail = step_q.pop_back();
                tail.run_last = 1'b1;
                step_q.push_back(tail);
            end
            foreach (step_q[i])
            begin
                decoded_q.push_back(step_q[i]);
            end
        endfunction

        function string describe(res_t r);
            return $sformatf("byte=%02h valid=%0b run_last=%0b done=%0b err=%0d",
                             r.out_byte, r.byte_valid, r.run_last, r.string_done, r.error_code);
        endfunction

        function void check_output(res_t got);
            res_t want;
            if (decoded_q.size() == 0)
            begin
                failures++;
                if (reported < 10)
                begin
                    $display("%0t: output with nothing expected: %s", $time, describe(got));
                end
                reported++;
                return;
            end
            want = decoded_q.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.run_last !== want.run_last || got.string_done !== want.string_done ||
                got.error_code !== want.error_code)
            begin
                failures++;
                if (reported < 10)
                begin
                    $display("%0t: output mismatch: expected %s, got %s",
                             $time, describe(want), describe(got));
                end
                reported++;
            end
        endfunction

        function int outstanding();
            return decoded_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sed_in_if in_ch ();
    sed_out_if out_ch ();

    string_escape_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    literal_decoder_model model = new();
    lit_byte_t stim_q[$];
    lit_byte_t lit_q[$];
    int accepted_inputs = 0;
    int cycles = 0;
    int send_pct = 0;
    int recv_pct = 0;
    bit quiet = 1'b0;
    bit holding = 1'b0;
    bit hold_done = 1'b0;

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                model.take_input_byte(in_ch.in_byte, in_ch.in_last);
                accepted_inputs++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got.out_byte = out_ch.out_byte;
                got.byte_valid = out_ch.byte_valid;
                got.run_last = out_ch.run_last;
                got.string_done = out_ch.string_done;
                got.error_code = out_ch.error_code;
                model.check_output(got);
            end
        end
    end

    function automatic void put_byte(logic [BYTE_W-1:0] b);
        lit_q.push_back(lit_byte_t'{data: b, last: 1'b0});
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(logic [3:0] n);
        if (n < 10)
        begin
            return 8'("0" + n);
        end
        return 8'(($urandom_range(1) ? "a" : "A") + n - 10);
    endfunction

    function automatic void put_hex(logic [ACC_W-1:0] v, int digits);
        for (int i = digits - 1; i >= 0; i--)
        begin
            put_byte(hex_char(v[4*i +: 4]));
        end
    endfunction

    function automatic void put_u(logic [ACC_W-1:0] v, bit upper);
        put_byte(CH_BSLASH);
        put_byte(upper ? CH_U_UP : CH_U_LO);
        put_hex(v, 4);
    endfunction

    function automatic bit is_simple_escape(logic [BYTE_W-1:0] c);
        case (c)
            CH_SQUOTE, CH_DQUOTE, CH_BSLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pick_simple_escape();
        logic [BYTE_W-1:0] c;
        do c = 8'($urandom_range(255)); while (!is_simple_escape(c));
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_plain();
        logic [BYTE_W-1:0] c;
        do c = 8'($urandom_range(255)); while (c == CH_BSLASH);
        return c;
    endfunction

    function automatic logic [ACC_W-1:0] pick_bmp();
        logic [ACC_W-1:0] v;
        case ($urandom_range(9))
            0: v = 16'h0000;
            1: v = 16'h007F;
            2: v = 16'h0080;
            3: v = 16'h07FF;
            4: v = 16'h0800;
            5: v = 16'hFFFF;
            default: do v = 16'($urandom); while (v >= 16'hD800 && v <= 16'hDFFF);
        endcase
        return v;
    endfunction

    function automatic logic [ACC_W-1:0] pick_high();
        return 16'hD800 | 16'($urandom_range(1023));
    endfunction

    function automatic logic [ACC_W-1:0] pick_low();
        return 16'hDC00 | 16'($urandom_range(1023));
    endfunction

    function automatic void put_clean();
        int r;
        logic [BYTE_W-1:0] xv;
        r = $urandom_range(99);
        if (r < 25)
        begin
            put_byte(pick_plain());
        end
        else if (r < 30)
        begin
            put_byte(CH_DQUOTE);
        end
        else if (r < 45)
        begin
            put_byte(CH_BSLASH);
            put_byte(pick_simple_escape());
        end
        else if (r < 55)
        begin
            case ($urandom_range(5))
                0: xv = 8'h00;
                1: xv = 8'hFF;
                default: xv = 8'($urandom);
            endcase
            put_byte(CH_BSLASH);
            put_byte($urandom_range(1) ? CH_X_UP : CH_X_LO);
            put_hex({8'h00, xv}, 2);
        end
        else if (r < 67)
        begin
            put_u(pick_bmp(), $urandom_range(1));
        end
        else
        begin
            put_u(pick_high(), $urandom_range(1));
            if ($urandom_range(3) == 0)
            begin
                put_byte(CH_DQUOTE);
            end
            put_u(pick_low(), 1'b0);
        end
    endfunction

    function automatic void put_broken();
        logic [BYTE_W-1:0] c;
        int n;
        case ($urandom_range(9))
            0:
            begin
                put_byte(CH_BSLASH);
                do c = 8'($urandom_range(255));
                while (is_simple_escape(c) || c == CH_X_LO || c == CH_X_UP ||
                       c == CH_U_LO || c == CH_U_UP);
                put_byte(c);
            end
            1:
            begin
                put_byte(CH_BSLASH);
                if ($urandom_range(1))
                begin
                    put_byte($urandom_range(1) ? CH_X_UP : CH_X_LO);
                    n = $urandom_range(1);
                end
                else
                begin
                    put_byte($urandom_range(1) ? CH_U_UP : CH_U_LO);
                    n = $urandom_range(3);
                end
                put_hex(16'($urandom), n);
                do c = 8'($urandom_range(255));
                while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
                put_byte(c);
            end
            2:
            begin
                put_u(pick_high(), $urandom_range(1));
                do c = pick_plain(); while (c == CH_DQUOTE);
                put_byte(c);
            end
            3:
            begin
                put_u(pick_high(), $urandom_range(1));
                case ($urandom_range(2))
                    0:
                    begin
                        put_byte(CH_BSLASH);
                        put_byte(pick_simple_escape());
                    end
                    1:
                    begin
                        put_byte(CH_BSLASH);
                        put_byte(CH_X_LO);
                        put_hex(16'($urandom), 2);
                    end
                    default: put_u(pick_low(), 1'b1);
                endcase
            end
            4:
            begin
                put_u(pick_high(), $urandom_range(1));
                put_u(pick_bmp(), 1'b0);
            end
            5:
            begin
                put_u(pick_high(), $urandom_range(1));
                put_u(pick_high(), 1'b0);
            end
            6: put_u(pick_low(), $urandom_range(1));
            7: put_u(pick_high(), $urandom_range(1));
            8:
            begin
                n = $urandom_range(4, 1);
                repeat (n) put_byte(8'($urandom));
            end
            default: put_byte(CH_BSLASH);
        endcase
    endfunction

    function automatic void close_literal();
        lit_byte_t tail;
        tail = lit_q.pop_back();
        tail.last = 1'b1;
        lit_q.push_back(tail);
        foreach (lit_q[i])
        begin
            stim_q.push_back(lit_q[i]);
        end
        lit_q.delete();
    endfunction

    // Builds one literal of random tokens, at most one of them malformed, sometimes truncates it, and queues its bytes.
    function automatic void build_random_literal();
        int tokens;
        int bad_at;
        int cut;
        tokens = $urandom_range(10, 1);
        bad_at = ($urandom_range(9) < 3) ? int'($urandom_range(tokens - 1)) : -1;
        lit_q.delete();
        for (int t = 0; t < tokens; t++)
        begin
            if (t == bad_at)
            begin
                put_broken();
            end
            else
            begin
                put_clean();
            end
        end
        if ($urandom_range(9) == 0 && lit_q.size() > 1)
        begin
            cut = $urandom_range(lit_q.size(), 1);
            while (lit_q.size() > cut)
            begin
                void'(lit_q.pop_back());
            end
        end
        close_literal();
    endfunction

    task automatic drive_item(lit_byte_t item);
        int gap;
        if (!quiet && !holding && $urandom_range(99) < send_pct)
        begin
            gap = $urandom_range(17, 1);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            in_ch.in_byte <= 8'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= item.data;
        in_ch.in_last <= item.last;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(63) == 0)
            begin
                recv_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 10);
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!hold_done && accepted_inputs >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                holding = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                holding = 1'b0;
                if (!quiet && $urandom_range(99) < recv_pct)
                begin
                    stall_left = $urandom_range(17, 1) - 1;
                    out_ch.ready <= 1'b0;
                end
                else
                begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= '0;
        in_ch.in_last <= 1'b0;

        put_byte(CH_DQUOTE);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(CH_BSLASH);
        put_byte(CH_N);
        put_byte(CH_BSLASH);
        put_byte(CH_X_UP);
        put_byte("F");
        put_byte("f");
        put_byte(CH_DQUOTE);
        close_literal();
        put_u(16'hD83D, 1'b0);
        put_u(16'hDE00, 1'b0);
        close_literal();

        while (stim_q.size() < TARGET_BYTES)
        begin
            build_random_literal();
        end

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_q[i])
        begin
            quiet = (stim_q.size() - i) < QUIET_TAIL;
            if (i == 0 || stim_q[i - 1].last)
            begin
                send_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(50, 10);
            end
            drive_item(stim_q[i]);
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;
        in_ch.in_last <= 1'b0;

        while (model.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (model.failures == 0 && model.outstanding() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: string_escape_decoder_core.f
src/sed_pkg.sv
src/sed_in_if.sv
src/sed_out_if.sv
src/string_escape_decoder_core.sv
verif/string_escape_decoder_core_test.sv
